[rtl/core/top_k_seek_tracker_core_assert.svh]
// Assertion macros shared by the checker of the seek tracker core.
// Each macro states one clocked property that is disabled while reset is held.
`ifndef TOP_K_SEEK_TRACKER_CORE_ASSERT_SVH
`define TOP_K_SEEK_TRACKER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKST_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tkst_pkg.sv]
// ----------------------------------------------------------------------------
// tkst_pkg
// Types and constants shared by the seek tracker core, its cells and checker.
// ----------------------------------------------------------------------------
package tkst_pkg;

	// Number of ranked slots in the table (one cell each).
	localparam int TOP_ENTRIES = 10;

	localparam int ID_W   = 16;
	localparam int CNT_W  = 24;
	localparam int SUM_W  = 32;
	localparam int RANK_W = 4;
	localparam int IDX_W  = 4;

	// Rank code used when a record does not enter the table, and in read mode.
	localparam logic [RANK_W-1:0] NO_RANK = RANK_W'(TOP_ENTRIES);

	typedef enum logic {
		MODE_LOG  = 1'b0,
		MODE_READ = 1'b1
	} mode_t;

	typedef struct packed {
		logic [ID_W-1:0]  file_id;
		logic [CNT_W-1:0] dblk_count;
		logic [CNT_W-1:0] actual_seeks;
		logic [CNT_W-1:0] possible_seeks;
	} entry_t;

	typedef struct packed {
		logic load;     // a log item is being accepted this cycle
		logic prev_gt;  // the neighbor above also gives way to the record
	} cell_ctl_t;

	typedef struct packed {
		mode_t            mode;
		logic [ID_W-1:0]  file_id;
		logic [CNT_W-1:0] file_data_blocks;
		logic [CNT_W-1:0] file_all_blocks;
		logic [CNT_W-1:0] file_possible_seeks;
		logic [CNT_W-1:0] file_actual_seeks;
		logic [IDX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] insert_rank;
		logic [ID_W-1:0]   entry_file_id;
		logic [CNT_W-1:0]  entry_data_blocks;
		logic [CNT_W-1:0]  entry_actual_seeks;
		logic [CNT_W-1:0]  entry_possible_seeks;
		logic [SUM_W-1:0]  sum_blocks;
		logic [SUM_W-1:0]  sum_possible_seeks;
		logic [SUM_W-1:0]  sum_actual_seeks;
	} out_item_t;

endpackage

[rtl/core/tkst_cell.sv]
// ----------------------------------------------------------------------------
// tkst_cell
// One table slot: compares the incoming record and shifts or loads in place.
// ----------------------------------------------------------------------------
module tkst_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tkst_pkg::cell_ctl_t ctl,
	input  tkst_pkg::entry_t   rec,
	input  tkst_pkg::entry_t   prev_entry,
	output logic               gt,
	output tkst_pkg::entry_t   entry
);
	import tkst_pkg::*;

	entry_t entry_q;

	// The table is kept non-increasing, so the cells that give way form a
	// contiguous run at the bottom; the first of them takes the record.
	assign gt    = rec.actual_seeks > entry_q.actual_seeks;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.load && gt) begin
			entry_q <= ctl.prev_gt ? prev_entry : rec;
		end
	end

endmodule

[rtl/core/tkst_sat_acc.sv]
// ----------------------------------------------------------------------------
// tkst_sat_acc
// Running total that saturates at its all-ones value.
// ----------------------------------------------------------------------------
module tkst_sat_acc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [tkst_pkg::CNT_W-1:0]  addend,
	output logic [tkst_pkg::SUM_W-1:0]  sum_next,
	output logic [tkst_pkg::SUM_W-1:0]  sum
);
	import tkst_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   raw;

	assign raw      = {1'b0, sum_q} + {{(SUM_W+1-CNT_W){1'b0}}, addend};
	assign sum_next = raw[SUM_W] ? {SUM_W{1'b1}} : raw[SUM_W-1:0];
	assign sum      = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_next;
		end
	end

endmodule

[rtl/core/top_k_seek_tracker_core.sv]
// ----------------------------------------------------------------------------
// top_k_seek_tracker_core
// Ranked table of the files with the most seeks, plus saturating totals.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle and shows its result in the cycle
// after acceptance, held in an output register until it is taken; while that
// register is full and not being drained, in_ready is low. The rate is set by
// the row of table cells: every cell compares the incoming seek count with
// its own slot and either keeps its entry, takes the record, or takes the
// entry of the cell above, all in the same cycle, so a log item finishes the
// whole sorted insertion in one step. A log item (mode 0) adds its total
// blocks, potential seeks and actual seeks to three running totals that stop
// at 4294967295, and enters the table at the first slot holding strictly
// fewer seeks; entries with an equal count stay above it, the last entry
// drops off, and a record with zero seeks never enters. Its result reports
// the slot taken (TOP_ENTRIES when none), zeros in the entry fields and the
// totals after the addition. A read item (mode 1) returns the slot at
// read_index, or an all-zero entry when the index is past the table, along
// with the unchanged totals. Reset empties the table and clears the totals
// at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module top_k_seek_tracker_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tkst_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tkst_pkg::out_item_t  out_item
);
	import tkst_pkg::*;

	logic      accept;
	logic      log_en;
	entry_t    rec;

	// Per-cell signals of the insertion chain.
	logic      cell_gt    [TOP_ENTRIES];
	entry_t    cell_entry [TOP_ENTRIES];
	entry_t    cell_prev  [TOP_ENTRIES];
	cell_ctl_t cell_ctl   [TOP_ENTRIES];

	logic [RANK_W-1:0] rank;
	entry_t            read_entry;

	logic [SUM_W-1:0] blk_next, blk_sum;
	logic [SUM_W-1:0] pos_next, pos_sum;
	logic [SUM_W-1:0] act_next, act_sum;

	out_item_t out_d;
	out_item_t out_q;
	logic      out_valid_q;

	// The output register frees up in the same cycle it is drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign log_en   = accept && (in_item.mode == MODE_LOG);

	assign rec.file_id        = in_item.file_id;
	assign rec.dblk_count     = in_item.file_data_blocks;
	assign rec.actual_seeks   = in_item.file_actual_seeks;
	assign rec.possible_seeks = in_item.file_possible_seeks;

	// Each cell hears whether its upper neighbor also gives way; the top cell
	// has no neighbor, so whenever it loads, it takes the record itself.
	always_comb begin
		for (int i = 0; i < TOP_ENTRIES; i++) begin
			cell_ctl[i].load = log_en;
			if (i == 0) begin
				cell_ctl[i].prev_gt = 1'b0;
				cell_prev[i]        = rec;
			end else begin
				cell_ctl[i].prev_gt = cell_gt[i-1];
				cell_prev[i]        = cell_entry[i-1];
			end
		end
	end

	for (genvar g = 0; g < TOP_ENTRIES; g++) begin : g_cell
		tkst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[g]),
			.rec        (rec),
			.prev_entry (cell_prev[g]),
			.gt         (cell_gt[g]),
			.entry      (cell_entry[g])
		);
	end

	// Insertion slot: the first cell that gives way. Since the give-way flags
	// are monotonic down the chain, a priority pick from the bottom finds it.
	always_comb begin
		rank = NO_RANK;
		for (int i = TOP_ENTRIES - 1; i >= 0; i--) begin
			if (cell_gt[i]) begin
				rank = RANK_W'(i);
			end
		end
	end

	// Read path: AND-OR select over the cells; an index past the table
	// matches no cell and reads as an empty entry.
	always_comb begin
		read_entry = '0;
		for (int i = 0; i < TOP_ENTRIES; i++) begin
			if (int'(in_item.read_index) == i) begin
				read_entry = read_entry | cell_entry[i];
			end
		end
	end

	tkst_sat_acc u_blk_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (log_en),
		.addend   (in_item.file_all_blocks),
		.sum_next (blk_next),
		.sum      (blk_sum)
	);

	tkst_sat_acc u_pos_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (log_en),
		.addend   (in_item.file_possible_seeks),
		.sum_next (pos_next),
		.sum      (pos_sum)
	);

	tkst_sat_acc u_act_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (log_en),
		.addend   (in_item.file_actual_seeks),
		.sum_next (act_next),
		.sum      (act_sum)
	);

	// Result assembly: log items report the slot taken and the new totals,
	// read items report the selected entry and the totals as they stand.
	always_comb begin
		out_d = '0;
		if (in_item.mode == MODE_LOG) begin
			out_d.insert_rank        = rank;
			out_d.sum_blocks         = blk_next;
			out_d.sum_possible_seeks = pos_next;
			out_d.sum_actual_seeks   = act_next;
		end else begin
			out_d.insert_rank          = NO_RANK;
			out_d.entry_file_id        = read_entry.file_id;
			out_d.entry_data_blocks    = read_entry.dblk_count;
			out_d.entry_actual_seeks   = read_entry.actual_seeks;
			out_d.entry_possible_seeks = read_entry.possible_seeks;
			out_d.sum_blocks           = blk_sum;
			out_d.sum_possible_seeks   = pos_sum;
			out_d.sum_actual_seeks     = act_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/core/tkst_checker.sv]
// ----------------------------------------------------------------------------
// tkst_checker
// Port-level checks of the seek tracker core, bound to the top level.
// ----------------------------------------------------------------------------
`include "top_k_seek_tracker_core_assert.svh"

module tkst_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input tkst_pkg::in_item_t   in_item,
	input logic                 out_valid,
	input logic                 out_ready,
	input tkst_pkg::out_item_t  out_item
);
	import tkst_pkg::*;

	logic out_take;
	logic log_result;

	assign out_take   = out_valid && out_ready;
	assign log_result = out_valid && (out_item.insert_rank != NO_RANK);

	// A result that reports a slot comes from a log item, so its entry is empty.
	`TKST_ASSERT_SAME(a_log_entry_empty, clk, arst_n, log_result, (out_item.entry_file_id == '0) && (out_item.entry_data_blocks == '0) && (out_item.entry_actual_seeks == '0) && (out_item.entry_possible_seeks == '0), "log result carries a table entry")

	// Reported slots never lie past the end of the table.
	`TKST_ASSERT_SAME(a_rank_range, clk, arst_n, out_valid, out_item.insert_rank <= NO_RANK, "insert rank out of range")

	// Totals only grow from one delivered result to the next.
	`TKST_ASSERT_SAME(a_totals_grow, clk, arst_n, out_valid && $past(out_take), (out_item.sum_blocks >= $past(out_item.sum_blocks)) && (out_item.sum_possible_seeks >= $past(out_item.sum_possible_seeks)) && (out_item.sum_actual_seeks >= $past(out_item.sum_actual_seeks)), "running total decreased")

	// A stalled result stays on the port unchanged.
	`TKST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind top_k_seek_tracker_core tkst_checker u_tkst_checker (.*);
